### rtl/bitmap_frame_allocator_defines.svh
// assertion macros for the bitmap frame allocator
// no dependencies; included by the files that carry assertions
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
// no dependencies; used by the top level and the testbench
package bfa_pkg;

	localparam int unsigned BLOCK_COUNT = 4096;
	// block size, a power of two
	localparam int unsigned BLOCK_BYTES = 4096;
	localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int unsigned BLK_ADDR_W  = 32 - BLOCK_SHIFT;
	localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

	typedef enum logic [1:0] {
		REQ_ALLOC          = 2'd0,
		REQ_FREE           = 2'd1,
		REQ_REGION_FREE    = 2'd2,
		REQ_REGION_RESERVE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOM     = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t   req_type;
		logic [31:0] byte_address;
		logic [31:0] region_bytes;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [23:0] block_address;
		logic [12:0] used_blocks;
	} rsp_t;

	// index of the single set bit
	function automatic logic [4:0] onehot_to_idx(input logic [31:0] oh);
		logic [4:0] idx;
		idx = '0;
		for (int k = 0; k < 32; k++) begin
			if (oh[k]) begin
				idx = idx | 5'(k);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/bfa_stream_if.sv
// valid/ready stream channel carrying one word per handshake
// payload type given at instantiation, usually a bfa_pkg struct
interface bfa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/bfa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module bfa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/bitmap_frame_allocator.sv
// bitmap frame allocator: one bit per block in a word ram, walked one word a cycle
// reset: a sweep over all MAP_WORDS words (128 by default) fills the map with ones, no request taken
// alloc: scans from word 0 up to the first word with a free bit, else oom
// free and region ops walk the words spanned (none if empty); region free also reserves block 0
// one request at a time, set by the single read port walked in the scan/walk loop
// depends on bfa_pkg, bfa_stream_if, bfa_ram and bitmap_frame_allocator_defines.svh
`include "bitmap_frame_allocator_defines.svh"

module bitmap_frame_allocator #(
	parameter int unsigned BLOCK_COUNT = bfa_pkg::BLOCK_COUNT
) (
	input logic         clk,
	input logic         arst_n,
	bfa_stream_if.sink   req,
	bfa_stream_if.source rsp
);
	localparam int unsigned MAP_WORDS = (BLOCK_COUNT + 31) / 32;
	localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned PTR_W     = WORD_W + 1;
	localparam int unsigned CNT_W     = $clog2(BLOCK_COUNT + 1);
	localparam int unsigned AW        = bfa_pkg::BLK_ADDR_W;

	typedef enum logic [6:0] {
		S_INIT  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SETUP = 7'b0000100,
		S_CLIP  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_WALK  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [PTR_W-1:0]     last_q;
	logic                 pend_q;
	logic [WORD_W-1:0]    pend_addr_q;
	logic [WORD_W-1:0]    first_q;
	logic [31:0]          lo_mask_q;
	logic [31:0]          hi_mask_q;
	logic                 mark_q;
	logic                 mark0_q;
	bfa_pkg::req_t        req_q;
	logic [AW-1:0]        start_q;
	logic [AW:0]          end_q;
	bfa_pkg::status_t     status_q;
	logic [23:0]          baddr_q;
	logic [CNT_W-1:0]     cnt_q;
	bfa_pkg::rsp_t        rsp_q;
	logic                 out_vld_q;

	logic                 ram_we;
	logic [WORD_W-1:0]    ram_wa;
	logic [31:0]          ram_wd;
	logic [31:0]          rd_word;

	logic                 issue_more;
	logic                 hit;
	logic [31:0]          free_oh;
	logic [31:0]          word_mask;
	logic [31:0]          walk_word;
	logic [5:0]           delta;
	logic [31:0]          alloc_addr;
	logic [31:0]          addr_blk;
	logic [31:0]          len_blk;
	logic                 outside;
	logic                 empty;
	logic [31:0]          sw32;
	logic [31:0]          lw32;
	logic [4:0]           e_bits;
	logic [31:0]          hi_mask;
	logic [31:0]          cnt_ext;
	logic                 in_acc;

	bfa_ram #(
		.WIDTH (32),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ptr_q[WORD_W-1:0]),
		.rdata (rd_word)
	);

	assign req.ready = (state_q == S_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.payload = rsp_q;
	assign cnt_ext   = 32'(cnt_q);

	// word walk datapath
	assign issue_more = (ptr_q <= last_q);
	assign hit        = pend_q && (rd_word != bfa_pkg::ALL_ONES);
	assign free_oh    = ~rd_word & (rd_word + 32'd1);
	assign word_mask  = ((pend_addr_q == first_q) ? lo_mask_q : bfa_pkg::ALL_ONES)
		& ((pend_addr_q == last_q[WORD_W-1:0]) ? hi_mask_q : bfa_pkg::ALL_ONES);
	assign walk_word  = mark_q ? (rd_word | word_mask) : (rd_word & ~word_mask);
	assign delta      = 6'($countones(rd_word ^ walk_word));
	assign alloc_addr = 32'({pend_addr_q, bfa_pkg::onehot_to_idx(free_oh)})
		<< bfa_pkg::BLOCK_SHIFT;

	// region bounds
	assign addr_blk = req_q.byte_address >> bfa_pkg::BLOCK_SHIFT;
	assign len_blk  = (req_q.req_type == bfa_pkg::REQ_FREE) ? 32'd1
		: (req_q.region_bytes >> bfa_pkg::BLOCK_SHIFT);
	assign outside  = 32'(end_q) > 32'(BLOCK_COUNT);
	assign empty    = (32'(start_q) >= 32'(end_q)) || (32'(start_q) >= 32'(BLOCK_COUNT));
	assign sw32     = 32'(start_q) >> 5;
	assign lw32     = outside ? 32'((BLOCK_COUNT - 1) >> 5) : ((32'(end_q) - 32'd1) >> 5);
	assign e_bits   = outside ? 5'(BLOCK_COUNT % 32) : end_q[4:0];
	assign hi_mask  = (e_bits == 5'd0) ? bfa_pkg::ALL_ONES : ~(bfa_pkg::ALL_ONES << e_bits);

	always_comb begin
		ram_we = 1'b0;
		ram_wa = pend_addr_q;
		ram_wd = walk_word;
		unique case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_wa = ptr_q[WORD_W-1:0];
				ram_wd = bfa_pkg::ALL_ONES;
			end
			S_SCAN: begin
				ram_we = hit;
				ram_wd = rd_word | free_oh;
			end
			S_WALK: begin
				ram_we = pend_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			ptr_q     <= '0;
			last_q    <= '0;
			pend_q    <= 1'b0;
			mark0_q   <= 1'b0;
			cnt_q     <= CNT_W'(BLOCK_COUNT);
			out_vld_q <= 1'b0;
		end else begin
			// a result loaded in S_RESP keeps valid high
			if (rsp.valid && rsp.ready && (state_q != S_RESP)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + PTR_W'(1);
					if (ptr_q == PTR_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						req_q   <= req.payload;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					start_q <= addr_blk[AW-1:0];
					end_q   <= (AW + 1)'(addr_blk[AW-1:0]) + (AW + 1)'(len_blk[AW-1:0]);
					pend_q  <= 1'b0;
					if (req_q.req_type == bfa_pkg::REQ_ALLOC) begin
						ptr_q   <= '0;
						last_q  <= PTR_W'(MAP_WORDS - 1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_CLIP;
					end
				end
				S_CLIP: begin
					status_q <= outside ? bfa_pkg::ST_OUTSIDE : bfa_pkg::ST_OK;
					baddr_q  <= '0;
					if (!empty) begin
						first_q   <= sw32[WORD_W-1:0];
						ptr_q     <= sw32[PTR_W-1:0];
						last_q    <= lw32[PTR_W-1:0];
						lo_mask_q <= bfa_pkg::ALL_ONES << start_q[4:0];
						hi_mask_q <= hi_mask;
						mark_q    <= (req_q.req_type == bfa_pkg::REQ_REGION_RESERVE);
						mark0_q   <= (req_q.req_type == bfa_pkg::REQ_REGION_FREE);
						state_q   <= S_WALK;
					end else if (req_q.req_type == bfa_pkg::REQ_REGION_FREE) begin
						// nothing to clear, go straight to reserving block 0
						first_q   <= '0;
						ptr_q     <= '0;
						last_q    <= '0;
						lo_mask_q <= bfa_pkg::ALL_ONES;
						hi_mask_q <= 32'd1;
						mark_q    <= 1'b1;
						mark0_q   <= 1'b0;
						state_q   <= S_WALK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (hit) begin
						cnt_q    <= cnt_q + CNT_W'(1);
						status_q <= bfa_pkg::ST_OK;
						baddr_q  <= alloc_addr[23:0];
						pend_q   <= 1'b0;
						state_q  <= S_RESP;
					end else begin
						pend_q      <= issue_more;
						pend_addr_q <= ptr_q[WORD_W-1:0];
						if (issue_more) begin
							ptr_q <= ptr_q + PTR_W'(1);
						end
						if (!pend_q && !issue_more) begin
							status_q <= bfa_pkg::ST_OOM;
							baddr_q  <= '0;
							state_q  <= S_RESP;
						end
					end
				end
				S_WALK: begin
					if (pend_q) begin
						if (mark_q) begin
							cnt_q <= cnt_q + CNT_W'(delta);
						end else begin
							cnt_q <= cnt_q - CNT_W'(delta);
						end
					end
					pend_q      <= issue_more;
					pend_addr_q <= ptr_q[WORD_W-1:0];
					if (issue_more) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (!pend_q && !issue_more) begin
						if (mark0_q) begin
							// last write has landed, now reserve block 0
							first_q   <= '0;
							ptr_q     <= '0;
							last_q    <= '0;
							lo_mask_q <= bfa_pkg::ALL_ONES;
							hi_mask_q <= 32'd1;
							mark_q    <= 1'b1;
							mark0_q   <= 1'b0;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						rsp_q.status        <= status_q;
						rsp_q.block_address <= baddr_q;
						rsp_q.used_blocks   <= cnt_ext[12:0];
						out_vld_q           <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BFA_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, 32'(cnt_q) <= 32'(BLOCK_COUNT), "used count above block count")
	`BFA_ASSERT_NEXT(a_acc_setup, clk, arst_n, in_acc, state_q == S_SETUP, "accepted word did not start setup")
	`BFA_ASSERT_NOW(a_we_state, clk, arst_n, ram_we, (state_q == S_INIT) || (state_q == S_SCAN) || (state_q == S_WALK), "map write outside walk")
	`BFA_ASSERT_NOW(a_resp_idle, clk, arst_n, state_q == S_RESP, !pend_q, "result taken with a word read in flight")
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for bitmap_frame_allocator: directed and random requests with a scoreboard
// depends on bfa_pkg, bfa_stream_if and the allocator rtl
module testbench;
	import bfa_pkg::*;

	localparam int unsigned MAP_WORDS   = BLOCK_COUNT / 32;
	localparam int          CYCLE_LIMIT = 2_000_000;

	logic clk;
	logic arst_n;

	bfa_stream_if #(.payload_t(req_t)) req_if ();
	bfa_stream_if #(.payload_t(rsp_t)) rsp_if ();

	bitmap_frame_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// shadow of the allocator state
	logic [31:0] usage_map [MAP_WORDS];
	int unsigned used_total;

	rsp_t rsp_due [$];
	int   errors;
	int   cycles;
	bit   quiet;
	int   stall_left;

	always #2 clk = ~clk;

	function automatic void take_block(input int unsigned b);
		if (!usage_map[b / 32][b % 32]) begin
			usage_map[b / 32][b % 32] = 1'b1;
			used_total++;
		end
	endfunction

	function automatic void release_block(input int unsigned b);
		if (usage_map[b / 32][b % 32]) begin
			usage_map[b / 32][b % 32] = 1'b0;
			used_total--;
		end
	endfunction

	// applies one request to the shadow map and returns the response it earns
	function automatic rsp_t serve_request(input req_t r);
		rsp_t        o;
		logic [63:0] first;
		logic [63:0] last;
		int unsigned idx;
		bit          hit;
		o.status        = ST_OK;
		o.block_address = '0;
		hit             = 1'b0;
		idx             = 0;
		case (r.req_type)
			REQ_ALLOC: begin
				for (int w = 0; w < MAP_WORDS && !hit; w++) begin
					if (usage_map[w] != ALL_ONES) begin
						for (int k = 0; k < 32 && !hit; k++) begin
							if (!usage_map[w][k]) begin
								hit = 1'b1;
								idx = w * 32 + k;
							end
						end
					end
				end
				if (hit) begin
					take_block(idx);
					o.block_address = 24'(64'(idx) * BLOCK_BYTES);
				end else begin
					o.status = ST_OOM;
				end
			end
			REQ_FREE: begin
				idx = r.byte_address / BLOCK_BYTES;
				if (idx < BLOCK_COUNT) begin
					release_block(idx);
				end else begin
					o.status = ST_OUTSIDE;
				end
			end
			default: begin
				// region walk, clipped at the top of the map, no wrap
				first = 64'(r.byte_address / BLOCK_BYTES);
				last  = first + 64'(r.region_bytes / BLOCK_BYTES);
				if (last > 64'(BLOCK_COUNT)) begin
					o.status = ST_OUTSIDE;
					last     = 64'(BLOCK_COUNT);
				end
				for (logic [63:0] b = first; b < last; b++) begin
					if (r.req_type == REQ_REGION_RESERVE) begin
						take_block(32'(b));
					end else begin
						release_block(32'(b));
					end
				end
				if (r.req_type == REQ_REGION_FREE) begin
					take_block(0);
				end
			end
		endcase
		o.used_blocks = 13'(used_total);
		return o;
	endfunction

	// mostly no gap or a short one, now and then a long one
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 50) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// byte address of a block inside the map, or now and then anywhere
	function automatic logic [31:0] pick_address();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom;
		end
		return ($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES) + $urandom_range(0, BLOCK_BYTES - 1);
	endfunction

	function automatic logic [31:0] pick_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			return ($urandom_range(0, 16) * BLOCK_BYTES) + $urandom_range(0, BLOCK_BYTES - 1);
		end else if (pick < 95) begin
			return $urandom_range(0, 32'h0100_0000);
		end
		return $urandom;
	endfunction

	task automatic send_req(input req_kind_t kind, input logic [31:0] addr,
			input logic [31:0] len);
		int gap;
		gap = idle_len();
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= '{req_type: kind, byte_address: addr, region_bytes: len};
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	// response side stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			rsp_if.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				stall_left <= idle_len();
			end
		end
	end

	// scoreboard: shadow update on each request word, compare on each response word
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (req_if.valid && req_if.ready) begin
			rsp_due.push_back(serve_request(req_if.payload));
		end
		if (rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (rsp_due.size() == 0) begin
				$display("%0t: response with none pending: status %0d addr %h used %0d",
					$time, got.status, got.block_address, got.used_blocks);
				errors++;
			end else begin
				want = rsp_due.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
					errors++;
				end
				if (got.block_address !== want.block_address) begin
					$display("%0t: block_address expected %h got %h", $time,
						want.block_address, got.block_address);
					errors++;
				end
				if (got.used_blocks !== want.used_blocks) begin
					$display("%0t: used_blocks expected %0d got %0d", $time,
						want.used_blocks, got.used_blocks);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_corner_cases();
		send_req(REQ_ALLOC, 32'h0, 32'h0);                      // map full after reset
		send_req(REQ_FREE, 32'hffff_ffff, 32'h0);               // block outside map
		send_req(REQ_FREE, 32'h0000_0000, 32'h0);               // plain free of block 0
		send_req(REQ_ALLOC, 32'hffff_ffff, 32'hffff_ffff);      // hands back address 0
		send_req(REQ_FREE, 32'h0000_1000, 32'h0);
		send_req(REQ_FREE, 32'h0000_1fff, 32'h0);               // already free
		send_req(REQ_REGION_FREE, 32'h0000_5000, 32'h0000_0fff); // empty region
		send_req(REQ_REGION_FREE, 32'h0000_0000, 32'h0100_0000); // whole map
		send_req(REQ_ALLOC, 32'h0, 32'h0);
		send_req(REQ_REGION_RESERVE, 32'h00ff_e000, 32'h0000_4000); // past the top
		send_req(REQ_REGION_RESERVE, 32'hffff_f000, 32'hffff_ffff); // start beyond, no wrap
		send_req(REQ_REGION_FREE, 32'h0080_0000, 32'hffff_ffff);
		send_req(REQ_REGION_RESERVE, 32'h0000_0000, 32'hffff_ffff);
		send_req(REQ_ALLOC, 32'h0, 32'h0);
		send_req(REQ_REGION_FREE, 32'h0000_3fff, 32'h0000_1fff);
		send_req(REQ_ALLOC, 32'h0, 32'h0);
		send_req(REQ_REGION_FREE, 32'h00ff_f000, 32'h0000_1000); // last block only
		send_req(REQ_ALLOC, 32'h0, 32'h0);                       // deepest scan
		send_req(REQ_FREE, 32'h00ff_ffff, 32'h0);
		send_req(REQ_FREE, 32'h0100_0000, 32'h0);
		send_req(REQ_REGION_FREE, 32'hffff_ffff, 32'h0);
		send_req(REQ_REGION_RESERVE, 32'h0000_0000, 32'h0000_0000);
	endtask

	task automatic test_random_mix(input int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_req(REQ_ALLOC, $urandom, $urandom);
			end else if (pick < 65) begin
				send_req(REQ_FREE, pick_address(), $urandom);
			end else if (pick < 80) begin
				send_req(REQ_REGION_FREE, pick_address(), pick_length());
			end else if (pick < 95) begin
				send_req(REQ_REGION_RESERVE, pick_address(), pick_length());
			end else begin
				send_req(req_kind_t'($urandom_range(0, 3)), $urandom, $urandom);
			end
		end
	endtask

	// fill the map, open a small window, then alloc it dry and one more
	task automatic test_exhaust(input int rounds);
		int unsigned width;
		int unsigned base;
		repeat (rounds) begin
			width = $urandom_range(1, 8);
			base  = $urandom_range(1, BLOCK_COUNT - width);
			send_req(REQ_REGION_RESERVE, 32'h0, 32'h0100_0000);
			send_req(REQ_REGION_FREE, base * BLOCK_BYTES, width * BLOCK_BYTES);
			repeat (width + 1) send_req(REQ_ALLOC, $urandom, $urandom);
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		errors         = 0;
		cycles         = 0;
		quiet          = 1'b0;
		stall_left     = 0;
		for (int w = 0; w < MAP_WORDS; w++) begin
			usage_map[w] = ALL_ONES;
		end
		used_total = BLOCK_COUNT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_corner_cases();
		test_random_mix(700);
		test_exhaust(10);
		quiet = 1'b1;
		test_random_mix(200);
		quiet = 1'b0;
		test_random_mix(600);
		req_if.valid <= 1'b0;

		while (rsp_due.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
